[rtl/hvt_pkg.sv]
// ============================================================================
// hvt_pkg
// Shared types, constants and helpers of the homogeneous vertex transform.
// ============================================================================
package hvt_pkg;

  localparam int NUM_ROWS  = 4;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;
  localparam int COORD_W   = 32;
  localparam int ENTRY_W   = 16;
  localparam int PROD_W    = COORD_W + ENTRY_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int QUOT_W    = 32;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = QUOT_W / DIV_STEPS;
  localparam int NQ_W      = MAG_W - 12;

  localparam logic [DATA_W-1:0] ROW_RESET [NUM_ROWS] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  typedef struct packed {
    logic              div_mode;
    logic              wzero;
    logic [2:0]        ovf;
    logic [2:0]        neg;
    logic [NQ_W-1:0]   nq0;
    logic [NQ_W-1:0]   nq1;
    logic [NQ_W-1:0]   nq2;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0] val;
    logic               sat;
  } clamp_t;

  function automatic clamp_t clamp_q(input logic neg, input logic big,
                                     input logic [NQ_W-1:0] mag);
    clamp_t r;
    logic [NQ_W-1:0] neg_mag;
    neg_mag = '0 - mag;
    if (neg) begin
      if (big || mag > NQ_W'(33'h0_8000_0000)) begin
        r.val = 32'h8000_0000;
        r.sat = 1'b1;
      end else begin
        r.val = neg_mag[COORD_W-1:0];
        r.sat = 1'b0;
      end
    end else begin
      if (big || mag > NQ_W'(32'h7FFF_FFFF)) begin
        r.val = 32'h7FFF_FFFF;
        r.sat = 1'b1;
      end else begin
        r.val = mag[COORD_W-1:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

[rtl/hvt_if.sv]
// ============================================================================
// hvt_in_if / hvt_out_if
// Valid/ready channels carrying vertex requests and transformed results.
// ============================================================================
interface hvt_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  modport source (output valid, req_type, in_x, in_y, in_z, input ready);
  modport sink   (input valid, req_type, in_x, in_y, in_z, output ready);
endinterface

interface hvt_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic        w_was_zero;
  logic        saturated;
  modport source (output valid, out_x, out_y, out_z, w_was_zero, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, w_was_zero, saturated, output ready);
endinterface

[rtl/hvt_divider.sv]
// ============================================================================
// hvt_divider
// Pipelined restoring divider, two quotient bits per stage, 32-bit quotient.
// ============================================================================
module hvt_divider (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hvt_pkg::MAG_W-1:0] rem_in,
  input  logic [15:0]               low_in,
  input  logic [hvt_pkg::MAG_W-1:0] divisor,
  output logic [hvt_pkg::QUOT_W-1:0] quot
);

  localparam int NS = hvt_pkg::DIV_STAGES;
  localparam int MW = hvt_pkg::MAG_W;
  localparam int QW = hvt_pkg::QUOT_W;

  logic [MW-1:0] rem  [NS+1];
  logic [MW-1:0] dvs  [NS+1];
  logic [QW-1:0] dvd  [NS+1];
  logic [QW-1:0] qacc [NS+1];

  assign rem[0]  = rem_in;
  assign dvs[0]  = divisor;
  assign dvd[0]  = {low_in, 16'h0000};
  assign qacc[0] = '0;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [MW-1:0] r_next;
    logic [hvt_pkg::DIV_STEPS-1:0] q_next;

    always_comb begin
      logic [MW:0] t;
      r_next = rem[s];
      for (int k = 0; k < hvt_pkg::DIV_STEPS; k++) begin
        t = {r_next, dvd[s][QW-1-k]};
        if (t >= {1'b0, dvs[s]}) begin
          t = t - {1'b0, dvs[s]};
          q_next[hvt_pkg::DIV_STEPS-1-k] = 1'b1;
        end else begin
          q_next[hvt_pkg::DIV_STEPS-1-k] = 1'b0;
        end
        r_next = t[MW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1]  <= r_next;
        dvs[s+1]  <= dvs[s];
        dvd[s+1]  <= dvd[s] << hvt_pkg::DIV_STEPS;
        qacc[s+1] <= {qacc[s][QW-1-hvt_pkg::DIV_STEPS:0], q_next};
      end
    end
  end

  assign quot = qacc[NS];

endmodule

[rtl/homogeneous_vertex_transform_core.sv]
// ============================================================================
// homogeneous_vertex_transform_core
// Q16.16 vertex times Q3.12 4x4 matrix with perspective divide and clamping.
// ============================================================================
// The core accepts one vertex per clock while the output side does not
// stall and returns one result per vertex, in order. The pipeline holds the
// input register, the multiply, sum, magnitude and range check stages, the
// sixteen stages of the divider, which produces two quotient bits per stage,
// and the output clamp stage. A stall on the output freezes the whole
// pipeline and drops the input ready. The matrix rows are written through the
// APB port at byte addresses 0, 8, 16 and 24 and should only be changed while
// no vertex is in flight.
module homogeneous_vertex_transform_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hvt_pkg::ADDR_W-1:0]  paddr,
  input  logic [hvt_pkg::DATA_W-1:0]  pwdata,
  output logic [hvt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  hvt_in_if.sink                      vtx_in,
  hvt_out_if.source                   vtx_out
);

  localparam int NS = hvt_pkg::DIV_STAGES;
  localparam int MW = hvt_pkg::MAG_W;

  logic [hvt_pkg::DATA_W-1:0] row [hvt_pkg::NUM_ROWS];
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = row[paddr[4:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hvt_pkg::NUM_ROWS; i++) row[i] <= hvt_pkg::ROW_RESET[i];
    end else if (cfg_wr) begin
      row[paddr[4:3]] <= pwdata;
    end
  end

  logic en;
  logic out_valid;
  assign en           = !(out_valid && !vtx_out.ready);
  assign vtx_in.ready = en;

  // Stage 1: input register.
  logic v1, point1;
  logic signed [31:0] x1 [3];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vtx_in.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      point1 <= !vtx_in.req_type;
      x1[0]  <= vtx_in.in_x;
      x1[1]  <= vtx_in.in_y;
      x1[2]  <= vtx_in.in_z;
    end
  end

  // Stage 2: products.
  logic v2, point2;
  logic signed [hvt_pkg::PROD_W-1:0] prod2 [3][4];
  logic signed [31:0] trans2 [4];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      point2 <= point1;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod2[r][c] <= x1[r] * $signed(row[r][16*c +: 16]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        trans2[c] <= point1 ? {row[3][16*c +: 16], 16'h0000} : 32'sd0;
      end
    end
  end

  // Stage 3: column sums.
  logic v3, point3;
  logic signed [hvt_pkg::ACC_W-1:0] acc3 [4];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      point3 <= point2;
      for (int c = 0; c < 4; c++) begin
        acc3[c] <= hvt_pkg::ACC_W'(prod2[0][c]) + hvt_pkg::ACC_W'(prod2[1][c])
                 + hvt_pkg::ACC_W'(prod2[2][c]) + hvt_pkg::ACC_W'(trans2[c]);
      end
    end
  end

  // Stage 4: magnitudes and signs.
  logic v4, div4, wzero4, wneg4;
  logic [MW-1:0] mag4 [3];
  logic [MW-1:0] wm4;
  logic [2:0] neg4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    logic signed [hvt_pkg::ACC_W-1:0] na;
    if (en) begin
      wzero4 <= point3 && (acc3[3] == '0);
      div4   <= point3 && (acc3[3] != '0);
      wneg4  <= acc3[3][hvt_pkg::ACC_W-1];
      na = -acc3[3];
      wm4    <= acc3[3][hvt_pkg::ACC_W-1] ? na[MW-1:0] : acc3[3][MW-1:0];
      for (int c = 0; c < 3; c++) begin
        na = -acc3[c];
        neg4[c] <= acc3[c][hvt_pkg::ACC_W-1];
        mag4[c] <= acc3[c][hvt_pkg::ACC_W-1] ? na[MW-1:0] : acc3[c][MW-1:0];
      end
    end
  end

  // Stage 5: quotient range check and divider setup.
  logic v5;
  hvt_pkg::side_t side5;
  logic [MW-1:0] rem5 [3];
  logic [15:0]   low5 [3];
  logic [MW-1:0] wm5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side5.div_mode <= div4;
      side5.wzero    <= wzero4;
      side5.nq0      <= mag4[0][MW-1:12];
      side5.nq1      <= mag4[1][MW-1:12];
      side5.nq2      <= mag4[2][MW-1:12];
      wm5            <= wm4;
      for (int c = 0; c < 3; c++) begin
        side5.ovf[c] <= {16'h0000, mag4[c]} >= {wm4, 16'h0000};
        side5.neg[c] <= div4 ? (neg4[c] ^ wneg4) : neg4[c];
        rem5[c]      <= {16'h0000, mag4[c][MW-1:16]};
        low5[c]      <= mag4[c][15:0];
      end
    end
  end

  // Stages 6 to 21: division, with the side information delayed alongside.
  logic [hvt_pkg::QUOT_W-1:0] quot [3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    hvt_divider u_div (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem5[c]),
      .low_in  (low5[c]),
      .divisor (wm5),
      .quot    (quot[c])
    );
  end

  logic           vd   [NS];
  hvt_pkg::side_t sd   [NS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v5;
      for (int i = 1; i < NS; i++) vd[i] <= vd[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side5;
      for (int i = 1; i < NS; i++) sd[i] <= sd[i-1];
    end
  end

  // Stage 22: clamp and output register.
  hvt_pkg::side_t sl;
  hvt_pkg::clamp_t cl [3];
  logic [hvt_pkg::NQ_W-1:0] nq [3];
  assign sl    = sd[NS-1];
  assign nq[0] = sl.nq0;
  assign nq[1] = sl.nq1;
  assign nq[2] = sl.nq2;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (sl.div_mode) begin
        cl[c] = hvt_pkg::clamp_q(sl.neg[c], sl.ovf[c], hvt_pkg::NQ_W'(quot[c]));
      end else begin
        cl[c] = hvt_pkg::clamp_q(sl.neg[c], 1'b0, nq[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vd[NS-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      vtx_out.out_x      <= cl[0].val;
      vtx_out.out_y      <= cl[1].val;
      vtx_out.out_z      <= cl[2].val;
      vtx_out.w_was_zero <= sl.wzero;
      vtx_out.saturated  <= cl[0].sat | cl[1].sat | cl[2].sat;
    end
  end
  assign vtx_out.valid = out_valid;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !vtx_out.ready) |-> !vtx_in.ready)
    else $error("Input accepted while the output transaction is stalled.");

  a_row0_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr[4:3] == 2'd0) |=> (row[0] == $past(pwdata)))
    else $error("Matrix row 0 did not take the written value.");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (en && vd[NS-1] && sl.div_mode && (sl.ovf != 3'b000)) |=> vtx_out.saturated)
    else $error("Quotient overflow did not set the saturated flag.");

  a_wzero_no_div: assert property (@(posedge clk) disable iff (rst)
    (en && vd[NS-1]) |-> !(sl.wzero && sl.div_mode))
    else $error("Divide selected although w was zero.");

endmodule
